@@ rtl/bkar_pkg.sv @@
// Shared types, constants and key code tables for the boot keyboard decoder.
package bkar_pkg;

  localparam int KEYS_PER_REPORT = 6;
  localparam int DATA_W          = 8;
  localparam int CNT_W           = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int IN_DATA_W       = DATA_W * (KEYS_PER_REPORT + 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 2'd1;

  localparam logic [CNT_W-1:0] DELAY_RST    = 16'd500;
  localparam logic [CNT_W-1:0] INTERVAL_RST = 16'd33;
  localparam logic [CNT_W-1:0] CNT_MAX      = 16'hFFFF;

  // Key codes and special result codes
  localparam logic [7:0] KEY_LEFT         = 8'h50;
  localparam logic [7:0] KEY_RIGHT        = 8'h4F;
  localparam logic [7:0] CODE_SHIFT_LEFT  = 8'h90;
  localparam logic [7:0] CODE_SHIFT_RIGHT = 8'h91;
  localparam logic [7:0] CODE_CTRL_LBRK   = 8'd27;
  localparam logic [7:0] CODE_CTRL_BSLASH = 8'd28;
  localparam logic [7:0] CODE_CTRL_RBRK   = 8'd29;

  localparam logic [7:0] MOD_CTRL_MASK  = 8'h11;
  localparam logic [7:0] MOD_SHIFT_MASK = 8'h22;

  typedef logic [KEYS_PER_REPORT-1:0][7:0] key_arr_t;

  // What one lane found for its key slot
  typedef struct packed {
    logic       held;
    logic       emit;
    logic       start;
    logic [7:0] code;
  } lane_res_t;

  typedef lane_res_t [KEYS_PER_REPORT-1:0] lane_arr_t;

  // One run of results waiting for the output
  typedef struct packed {
    logic [KEYS_PER_REPORT-1:0]      mask;
    logic [KEYS_PER_REPORT-1:0][7:0] chars;
  } run_t;

  // Codes that give the same character with or without shift
  function automatic logic [7:0] common_char(input logic [6:0] code);
    logic [7:0] ch;
    ch = 8'h00;
    if (code >= 7'd89 && code <= 7'd97) begin
      ch = 8'h31 + {1'b0, code} - 8'd89;
    end else begin
      case (code)
        7'd40:   ch = 8'h0A;
        7'd41:   ch = 8'h1B;
        7'd42:   ch = 8'h08;
        7'd43:   ch = 8'h09;
        7'd44:   ch = 8'h20;
        7'd84:   ch = 8'h2F;
        7'd85:   ch = 8'h2A;
        7'd86:   ch = 8'h2D;
        7'd87:   ch = 8'h2B;
        7'd88:   ch = 8'h0A;
        7'd98:   ch = 8'h30;
        7'd99:   ch = 8'h2E;
        7'd103:  ch = 8'h3D;
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

  function automatic logic [7:0] plain_char(input logic [6:0] code);
    logic [7:0] ch;
    ch = common_char(code);
    if (code >= 7'd4 && code <= 7'd29) begin
      ch = 8'h61 + {1'b0, code} - 8'd4;
    end else if (code >= 7'd30 && code <= 7'd38) begin
      ch = 8'h31 + {1'b0, code} - 8'd30;
    end else begin
      case (code)
        7'd39:   ch = 8'h30;
        7'd45:   ch = 8'h2D;
        7'd46:   ch = 8'h3D;
        7'd47:   ch = 8'h5B;
        7'd48:   ch = 8'h5D;
        7'd49:   ch = 8'h5C;
        7'd50:   ch = 8'h23;
        7'd51:   ch = 8'h3B;
        7'd52:   ch = 8'h27;
        7'd53:   ch = 8'h60;
        7'd54:   ch = 8'h2C;
        7'd55:   ch = 8'h2E;
        7'd56:   ch = 8'h2F;
        7'd74:   ch = 8'h84;
        7'd76:   ch = 8'h86;
        7'd77:   ch = 8'h85;
        7'd79:   ch = 8'h83;
        7'd80:   ch = 8'h82;
        7'd81:   ch = 8'h81;
        7'd82:   ch = 8'h80;
        default: ch = ch;
      endcase
    end
    return ch;
  endfunction

  function automatic logic [7:0] shift_char(input logic [6:0] code);
    logic [7:0] ch;
    ch = common_char(code);
    if (code >= 7'd4 && code <= 7'd29) begin
      ch = 8'h41 + {1'b0, code} - 8'd4;
    end else begin
      case (code)
        7'd30:   ch = 8'h21;
        7'd31:   ch = 8'h40;
        7'd32:   ch = 8'h23;
        7'd33:   ch = 8'h24;
        7'd34:   ch = 8'h25;
        7'd35:   ch = 8'h5E;
        7'd36:   ch = 8'h26;
        7'd37:   ch = 8'h2A;
        7'd38:   ch = 8'h28;
        7'd39:   ch = 8'h29;
        7'd45:   ch = 8'h5F;
        7'd46:   ch = 8'h2B;
        7'd47:   ch = 8'h7B;
        7'd48:   ch = 8'h7D;
        7'd49:   ch = 8'h7C;
        7'd50:   ch = 8'h7E;
        7'd51:   ch = 8'h3A;
        7'd52:   ch = 8'h22;
        7'd53:   ch = 8'h7E;
        7'd54:   ch = 8'h3C;
        7'd55:   ch = 8'h3E;
        7'd56:   ch = 8'h3F;
        default: ch = ch;
      endcase
    end
    return ch;
  endfunction

  function automatic logic [7:0] key_char(input logic [6:0] code, input logic shifted);
    return shifted ? shift_char(code) : plain_char(code);
  endfunction

endpackage

@@ rtl/boot_keyboard_to_ascii_repeat_unit.sv @@
// Top level: USB boot keyboard report decoder with typematic repeat.
// Path: an accepted beat's run is written into the output queue, then its first
//   character is registered onto out_tdata; later characters follow one per
//   cycle while out_tready is high.
// Throughput: one input beat per cycle while the two-run output queue has room;
//   a report gives at most six characters, sent through the single output register.
// Reset (rst_n low, synchronous): queue empty, no repeat, counters and
//   previous keys cleared, repeat delay 500 and interval 33 ticks.
module boot_keyboard_to_ascii_repeat_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // tdata: modifier_bits, key_0, key_1, key_2, key_3, key_4, key_5
  input  logic [bkar_pkg::IN_DATA_W-1:0]    in_tdata,
  // tuser: func (0 report, 1 millisecond tick)
  input  logic                              in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: char_code
  output logic [7:0]                        out_tdata,
  // tlast: last_of_run
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bkar_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bkar_pkg::CNT_W-1:0]        cfg_data
);
  import bkar_pkg::*;

  logic [CNT_W-1:0] delay_r;
  logic [CNT_W-1:0] interval_r;
  logic             accept;
  logic             shift;
  logic             ctrl;
  key_arr_t         keys;
  key_arr_t         prev_keys;
  lane_arr_t        lanes;
  logic             push;
  run_t             run;
  logic             has_room;

  // Configuration: always ready, writes beyond the list are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r    <= DELAY_RST;
      interval_r <= INTERVAL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_REPEAT_DELAY:    delay_r    <= cfg_data;
        REG_REPEAT_INTERVAL: interval_r <= cfg_data;
        default:             ;
      endcase
    end
  end

  // A beat enters whenever the queue can take a whole run
  assign in_tready = has_room;
  assign accept    = in_tvalid && in_tready;

  assign ctrl  = (in_tdata[7:0] & MOD_CTRL_MASK) != 8'h00;
  assign shift = (in_tdata[7:0] & MOD_SHIFT_MASK) != 8'h00;

  always_comb begin
    for (int i = 0; i < KEYS_PER_REPORT; i++) begin
      keys[i] = in_tdata[DATA_W*(i+1) +: DATA_W];
    end
  end

  // One lane per key slot, all decoded in the accept cycle
  for (genvar g = 0; g < KEYS_PER_REPORT; g++) begin : g_lane
    bkar_lane u_lane (
      .key       (keys[g]),
      .prev_keys (prev_keys),
      .shift     (shift),
      .ctrl      (ctrl),
      .res       (lanes[g])
    );
  end

  bkar_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .is_tick         (in_tuser),
    .shift           (shift),
    .keys            (keys),
    .lanes           (lanes),
    .repeat_delay    (delay_r),
    .repeat_interval (interval_r),
    .prev_keys       (prev_keys),
    .push            (push),
    .run             (run)
  );

  bkar_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .run        (run),
    .has_room   (has_room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ rtl/bkar_lane.sv @@
// One decode lane: a single key slot against the previous report.
module bkar_lane (
  input  logic [7:0]          key,
  input  bkar_pkg::key_arr_t  prev_keys,
  input  logic                shift,
  input  logic                ctrl,
  output bkar_pkg::lane_res_t res
);
  import bkar_pkg::*;

  logic       valid;
  logic       seen;
  logic [7:0] ch;

  always_comb begin
    valid = (key != 8'h00) && !key[7];
    seen  = 1'b0;
    for (int i = 0; i < KEYS_PER_REPORT; i++) begin
      if (prev_keys[i] == key) seen = 1'b1;
    end
    ch = key_char(key[6:0], shift);

    res       = '0;
    res.held  = valid;
    if (valid && !seen) begin
      if (shift && key == KEY_LEFT) begin
        res.emit = 1'b1;
        res.code = CODE_SHIFT_LEFT;
      end else if (shift && key == KEY_RIGHT) begin
        res.emit = 1'b1;
        res.code = CODE_SHIFT_RIGHT;
      end else if (ctrl && ch >= 8'h61 && ch <= 8'h7A) begin
        res.emit  = 1'b1;
        res.start = 1'b1;
        res.code  = ch - 8'h60;
      end else if (ctrl && ch >= 8'h41 && ch <= 8'h5A) begin
        res.emit  = 1'b1;
        res.start = 1'b1;
        res.code  = ch - 8'h40;
      end else if (ctrl && (ch == 8'h5B || ch == 8'h7B)) begin
        res.emit = 1'b1;
        res.code = CODE_CTRL_LBRK;
      end else if (ctrl && (ch == 8'h5C || ch == 8'h7C)) begin
        res.emit = 1'b1;
        res.code = CODE_CTRL_BSLASH;
      end else if (ctrl && (ch == 8'h5D || ch == 8'h7D)) begin
        res.emit = 1'b1;
        res.code = CODE_CTRL_RBRK;
      end else begin
        // zero characters still arm repeat, they just emit nothing
        res.emit  = (ch != 8'h00);
        res.start = 1'b1;
        res.code  = ch;
      end
    end
  end

endmodule

@@ rtl/bkar_merge.sv @@
// Merge stage: combines lane results, holds key and typematic state, builds runs.
module bkar_merge (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic                         is_tick,
  input  logic                         shift,
  input  bkar_pkg::key_arr_t           keys,
  input  bkar_pkg::lane_arr_t          lanes,
  input  logic [bkar_pkg::CNT_W-1:0]   repeat_delay,
  input  logic [bkar_pkg::CNT_W-1:0]   repeat_interval,
  output bkar_pkg::key_arr_t           prev_keys,
  output logic                         push,
  output bkar_pkg::run_t               run
);
  import bkar_pkg::*;

  key_arr_t         prev_r, prev_nxt;
  logic [6:0]       rkey_r, rkey_nxt;
  logic             rshift_r, rshift_nxt;
  logic [CNT_W-1:0] tsp_r, tsp_nxt;
  logic [CNT_W-1:0] tsr_r, tsr_nxt;
  logic             any_held;
  logic [7:0]       rep_ch;

  assign prev_keys = prev_r;

  always_comb begin
    prev_nxt   = prev_r;
    rkey_nxt   = rkey_r;
    rshift_nxt = rshift_r;
    tsp_nxt    = tsp_r;
    tsr_nxt    = tsr_r;
    any_held   = 1'b0;
    rep_ch     = key_char(rkey_r, rshift_r);
    run        = '0;

    if (accept && is_tick) begin
      if (tsp_r != CNT_MAX) tsp_nxt = tsp_r + 1'b1;
      if (tsr_r != CNT_MAX) tsr_nxt = tsr_r + 1'b1;
      if (rkey_r != 7'd0 && tsp_nxt >= repeat_delay && tsr_nxt >= repeat_interval) begin
        run.mask[0]  = (rep_ch != 8'h00);
        run.chars[0] = rep_ch;
        tsr_nxt      = '0;
      end
    end else if (accept) begin
      for (int i = 0; i < KEYS_PER_REPORT; i++) begin
        run.mask[i]  = lanes[i].emit;
        run.chars[i] = lanes[i].code;
        any_held     = any_held | lanes[i].held;
        // the highest slot that arms repeat wins
        if (lanes[i].start) begin
          rkey_nxt   = keys[i][6:0];
          rshift_nxt = shift;
          tsp_nxt    = '0;
          tsr_nxt    = '0;
        end
      end
      if (!any_held) rkey_nxt = 7'd0;
      prev_nxt = keys;
    end
  end

  assign push = accept && (run.mask != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '0;
      rkey_r   <= 7'd0;
      rshift_r <= 1'b0;
      tsp_r    <= '0;
      tsr_r    <= '0;
    end else begin
      prev_r   <= prev_nxt;
      rkey_r   <= rkey_nxt;
      rshift_r <= rshift_nxt;
      tsp_r    <= tsp_nxt;
      tsr_r    <= tsr_nxt;
    end
  end

endmodule

@@ rtl/bkar_outq.sv @@
// Two-run queue and serialiser feeding the registered result channel.
module bkar_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bkar_pkg::run_t run,
  output logic           has_room,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tlast
);
  import bkar_pkg::*;

  run_t                       q_r [2];
  logic                       wr_ptr_r;
  logic                       rd_ptr_r;
  logic [1:0]                 cnt_r, cnt_nxt;
  logic                       out_valid_r;
  logic [7:0]                 out_data_r;
  logic                       out_last_r;
  logic                       load;
  logic                       pop;
  logic [KEYS_PER_REPORT-1:0] head_mask;
  logic [KEYS_PER_REPORT-1:0] low_bit;
  logic [KEYS_PER_REPORT-1:0] rem_mask;
  logic [7:0]                 sel_char;

  assign has_room = (cnt_r != 2'd2);
  assign load     = (cnt_r != 2'd0) && (!out_valid_r || out_tready);

  always_comb begin
    head_mask = q_r[rd_ptr_r].mask;
    low_bit   = head_mask & (~head_mask + 1'b1);
    rem_mask  = head_mask & ~low_bit;
    sel_char  = 8'h00;
    for (int i = 0; i < KEYS_PER_REPORT; i++) begin
      if (low_bit[i]) sel_char = sel_char | q_r[rd_ptr_r].chars[i];
    end
  end

  assign pop = load && (rem_mask == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  // payload: a push never lands on the head while the head is in use
  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= run;
    if (load) begin
      q_r[rd_ptr_r].mask <= rem_mask;
      out_data_r         <= sel_char;
      out_last_r         <= (rem_mask == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= 1'b0;
      rd_ptr_r    <= 1'b0;
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      if (load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

@@ rtl/bkar_checker.sv @@
// Port-level checks for the decoder, bound to the top level.
module bkar_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic [7:0]                        out_tdata,
  input logic                              out_tlast,
  input logic                              out_tvalid,
  input logic                              out_tready
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a full queue always has a beat on offer
  a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with nothing to send");

  // a run keeps going without a gap until its last beat
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside a run");

endmodule

bind boot_keyboard_to_ascii_repeat_unit bkar_checker u_bkar_checker (.*);
